@@ rtl/wts_pkg.sv @@
package wts_pkg;

	// Width of a worker pointer; follows from the 5-bit worker_count register.
	localparam int PW = 5;

	// Width of one load table entry.
	localparam int LW = 31;

	// Configuration register indexes.
	localparam logic [1:0] REG_SCHED_MODE   = 2'd0;
	localparam logic [1:0] REG_WORKER_COUNT = 2'd1;
	localparam logic [1:0] REG_FILES_BLOCK  = 2'd2;

	// Scheduling mode codes.
	localparam logic [1:0] SM_CYCLIC = 2'd0;
	localparam logic [1:0] SM_BLOCK  = 2'd1;
	localparam logic [1:0] SM_LEAST  = 2'd2;
	localparam logic [1:0] SM_BAD    = 2'd3;

	// Input item kinds.
	localparam logic REQ_TARGET = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	// Search sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} wts_state_t;

	// Start of a least-loaded search.
	typedef struct packed {
		logic          go;
		logic [PW-1:0] slots;
	} wts_srch_ctl_t;

	// Search status back to the top level.
	typedef struct packed {
		logic          busy;
		logic          done;
		logic [PW-1:0] best;
	} wts_srch_stat_t;

endpackage

@@ rtl/wts_ram.sv @@
module wts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/wts_search.sv @@
module wts_search
	import wts_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  wts_srch_ctl_t  ctl,
	input  logic [LW-1:0]  load_rd,
	output logic [PW-1:0]  rd_idx,
	output wts_srch_stat_t stat
);

	wts_state_t    state_q, state_d;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] slots_q;
	logic          live_s1;
	logic [PW-1:0] didx_s1;
	logic [PW-1:0] best_q;
	logic [LW-1:0] best_load_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: issue one table read per cycle, then let the last one land.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == slots_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Address counter and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			slots_q <= '0;
			live_s1 <= 1'b0;
			didx_s1 <= '0;
		end else begin
			live_s1 <= (state_q == ST_SCAN);
			didx_s1 <= idx_q;
			if (state_q == ST_IDLE && ctl.go) begin
				idx_q   <= PW'(1);
				slots_q <= ctl.slots;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + PW'(1);
			end
		end
	end

	// The single comparator: a strictly smaller load takes over, so ties keep the lower worker.
	always_ff @(posedge clk) begin
		if (live_s1 && (didx_s1 == PW'(1) || load_rd < best_load_q)) begin
			best_q      <= didx_s1;
			best_load_q <= load_rd;
		end
	end

	assign rd_idx    = idx_q;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FIN);
	assign stat.best = best_q;

endmodule

@@ rtl/work_target_selector.sv @@
// Channel   Signals                                        Direction
// command   start, busy, mode, worker_id, load_value      in (busy out)
// result    done, target_worker, bad_mode                 out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     in (cfg_ready out)
//
// A load report is taken and gives no result.
// A cyclic, block or invalid-mode request gives its result in the next cycle.
// A least-loaded request keeps busy high while it scans slots load entries (slots
// is workers in use, 15 by default) and drains; its result follows, and the next
// item can start with it. One comparator reads the load memory one entry a cycle.
// Reset clears control state at once, not the load memory; load entries read as zero until reported.
// The receiver cannot stall: done marks a result for one cycle.
module work_target_selector
	import wts_pkg::*;
#(
	parameter int MAX_WORKERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          mode,
	input  logic [3:0]    worker_id,
	input  logic [LW-1:0] load_value,
	output logic          done,
	output logic [3:0]    target_worker,
	output logic          bad_mode,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int AW = $clog2(MAX_WORKERS);

	logic [1:0]             sched_q;
	logic [PW-1:0]          wcount_q;
	logic [15:0]            fpb_q;
	logic [PW-1:0]          cyc_q;
	logic [PW-1:0]          blk_q;
	logic [15:0]            fill_q;
	logic [MAX_WORKERS-1:0] vld_q;
	logic                   vld_s1;
	logic                   done_q;
	logic [3:0]             target_q;
	logic                   bad_q;

	logic           accept;
	logic           req;
	logic           rpt_we;
	logic [PW-1:0]  eff;
	logic [PW-1:0]  slots;
	logic [PW-1:0]  cyc_p;
	logic [PW-1:0]  blk_p;
	logic [PW-1:0]  cyc_inc;
	logic [PW-1:0]  blk_inc;
	logic [16:0]    fill_inc;
	logic [AW-1:0]  raddr;
	logic [LW-1:0]  rdata;
	logic [LW-1:0]  load_rd;
	logic [PW-1:0]  rd_idx;
	wts_srch_ctl_t  sctl;
	wts_srch_stat_t sstat;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign req       = accept && (mode == REQ_TARGET);
	assign rpt_we    = accept && (mode == REQ_REPORT) && (32'(worker_id) < MAX_WORKERS);

	// Effective worker count, clamped to the supported range.
	always_comb begin
		if (wcount_q < PW'(2)) begin
			eff = PW'(2);
		end else if (32'(wcount_q) > MAX_WORKERS) begin
			eff = PW'(MAX_WORKERS);
		end else begin
			eff = wcount_q;
		end
		slots = eff - PW'(1);
	end

	// Stale pointers fall back to the first worker, then step with wrap.
	always_comb begin
		cyc_p    = (cyc_q >= slots) ? '0 : cyc_q;
		blk_p    = (blk_q >= slots) ? '0 : blk_q;
		cyc_inc  = (cyc_p + PW'(1) >= slots) ? '0 : cyc_p + PW'(1);
		blk_inc  = (blk_p + PW'(1) >= slots) ? '0 : blk_p + PW'(1);
		fill_inc = {1'b0, fill_q} + 17'd1;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q  <= SM_CYCLIC;
			wcount_q <= PW'(16);
			fpb_q    <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCHED_MODE:   sched_q  <= cfg_data[1:0];
				REG_WORKER_COUNT: wcount_q <= cfg_data[PW-1:0];
				REG_FILES_BLOCK:  fpb_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pointers, block fill and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q    <= '0;
			blk_q    <= '0;
			fill_q   <= '0;
			done_q   <= 1'b0;
			target_q <= '0;
			bad_q    <= 1'b0;
		end else begin
			done_q <= sstat.done || (req && sched_q != SM_LEAST);
			if (sstat.done) begin
				target_q <= sstat.best[3:0];
				bad_q    <= 1'b0;
			end else if (req) begin
				unique case (sched_q)
					SM_CYCLIC: begin
						target_q <= 4'(cyc_p + PW'(1));
						bad_q    <= 1'b0;
						cyc_q    <= cyc_inc;
					end
					SM_BLOCK: begin
						target_q <= 4'(blk_p + PW'(1));
						bad_q    <= 1'b0;
						if (fill_inc >= {1'b0, fpb_q}) begin
							blk_q  <= blk_inc;
							fill_q <= '0;
						end else begin
							blk_q  <= blk_p;
							fill_q <= fill_inc[15:0];
						end
					end
					SM_BAD: begin
						target_q <= '0;
						bad_q    <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Valid bits stand for the cleared load table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_q[raddr];
			if (rpt_we) begin
				vld_q[AW'(worker_id)] <= 1'b1;
			end
		end
	end

	assign raddr   = AW'(rd_idx);
	assign load_rd = vld_s1 ? rdata : '0;

	wts_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WORKERS)
	) u_load_ram (
		.clk  (clk),
		.we   (rpt_we),
		.waddr(AW'(worker_id)),
		.wdata(load_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sctl.go    = req && (sched_q == SM_LEAST);
	assign sctl.slots = slots;

	wts_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.load_rd(load_rd),
		.rd_idx (rd_idx),
		.stat   (sstat)
	);

	assign busy          = sstat.busy;
	assign done          = done_q;
	assign target_worker = target_q;
	assign bad_mode      = bad_q;

endmodule

@@ rtl/wts_chk.sv @@
module wts_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       mode,
	input logic       done,
	input logic [3:0] target_worker,
	input logic       bad_mode
);

	// A load report never produces a result beat.
	a_report_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode) |=> !done)
		else $error("result beat after a load report");

	// An invalid-mode result always names no worker.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_mode) |-> (target_worker == 4'd0))
		else $error("invalid mode result with nonzero worker");

	// A valid result always names a real worker.
	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !bad_mode) |-> (target_worker != 4'd0))
		else $error("valid result names worker zero");

	// The block only goes busy after taking a target request.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && !$past(mode)))
		else $error("busy rose without a target request");

	// No result beat appears while a search is running.
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat while busy");

endmodule

bind work_target_selector wts_chk u_wts_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.done         (done),
	.target_worker(target_worker),
	.bad_mode     (bad_mode)
);
